// ===== rtl/two_tier_replica_selector_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Replica selector assertion macros
// Clocked on clk, quiet while arst_n is low. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef TWO_TIER_REPLICA_SELECTOR_UNIT_ASSERT_SVH
`define TWO_TIER_REPLICA_SELECTOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TTRS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("replica selector assertion failed");
`define TTRS_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("replica selector implication failed");
`else
`define TTRS_ASSERT(lbl, prop)
`define TTRS_IMPLY(lbl, ante, cons)
`endif
`endif

// ===== rtl/ttrs_pkg.sv =====
// ----------------------------------------------------------------------------
// ttrs_pkg
// Shared constants, codes and types of the two-tier replica selector.
// ----------------------------------------------------------------------------
`default_nettype none
package ttrs_pkg;

	localparam int REPLICAS_DEF    = 16;
	localparam int RING_POINTS_DEF = 256;
	localparam int HASH_BITS_DEF   = 32;

	localparam int KEY_W    = 32;
	localparam int IDX_W    = 4;
	localparam int CNT_W    = 16;
	localparam int WEIGHT_W = 8;
	localparam int MASK_W   = 16;
	localparam int LFSR_W   = 16;
	localparam int TIE_W    = 5;   // tie count reaches 16
	localparam int PROD_W   = CNT_W + WEIGHT_W;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_STATUS = 2'd2,
		CMD_SELECT = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BS_RD,
		S_BS_CMP,
		S_WK_RD,
		S_WK_CHK,
		S_FB_CHK,
		S_FB_CMP,
		S_FB_MOD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                start;
		logic [LFSR_W-1:0]   dividend;
		logic [TIE_W-1:0]    divisor;
	} mod_req_t;

	typedef struct packed {
		logic done;
		logic rem_zero;
	} mod_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/two_tier_replica_selector_unit.sv =====
// ----------------------------------------------------------------------------
// two_tier_replica_selector_unit
// Hash-ring replica selection with a least-connections fallback.
// ----------------------------------------------------------------------------
// Clear, append and status transactions are taken without a stall. A select
// runs a binary search for the first ring point at or above the key (a
// read state and a compare state per step), then walks the ring from there
// (a read state and a check state per point) until an eligible owner turns
// up, and if none does, scans the replica table with a single shared 16x8
// multiplier; a score tie calls on the bit-serial remainder unit. The ring
// memory has one read port. Input is stalled for the whole select; the
// result sits in an output register so the next transaction is taken while
// it waits. Ring memory is not cleared after reset: only entries below the
// point count are read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "two_tier_replica_selector_unit_assert.svh"
module two_tier_replica_selector_unit #(
	parameter int REPLICAS    = ttrs_pkg::REPLICAS_DEF,
	parameter int RING_POINTS = ttrs_pkg::RING_POINTS_DEF,
	parameter int HASH_BITS   = ttrs_pkg::HASH_BITS_DEF
) (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [ttrs_pkg::LFSR_W-1:0]     cfg_wdata,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire [1:0]                      command,
	input  wire [ttrs_pkg::KEY_W-1:0]      key_hash,
	input  wire [ttrs_pkg::IDX_W-1:0]      replica_index,
	input  wire                            present,
	input  wire                            draining,
	input  wire                            dead,
	input  wire [ttrs_pkg::CNT_W-1:0]      active_count,
	input  wire [ttrs_pkg::CNT_W-1:0]      cap_limit,
	input  wire [ttrs_pkg::WEIGHT_W-1:0]   weight,
	input  wire [ttrs_pkg::MASK_W-1:0]     excluded_mask,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic                           found,
	output logic [ttrs_pkg::IDX_W-1:0]     chosen_replica,
	output logic                           tier
);
	import ttrs_pkg::*;

	// replica index is 4 bits, so at most 16 table entries are reachable
	localparam int TBL   = (REPLICAS < 16) ? REPLICAS : 16;
	localparam int RW    = (TBL > 1) ? $clog2(TBL) : 1;
	localparam int FW    = $clog2(TBL + 1);
	localparam int POS_W = (HASH_BITS < KEY_W) ? HASH_BITS : KEY_W;
	localparam int AW    = (RING_POINTS > 1) ? $clog2(RING_POINTS) : 1;
	localparam int CW    = $clog2(RING_POINTS + 1);

	state_t state_q, state_nx;

	// ring storage
	logic [POS_W-1:0] pos_mem [RING_POINTS];
	logic [IDX_W-1:0] own_mem [RING_POINTS];
	logic [POS_W-1:0] pos_rd_q;
	logic [IDX_W-1:0] own_rd_q;
	logic [CW-1:0]    count_q;
	logic [POS_W-1:0] last_pos_q;
	logic [AW-1:0]    rd_addr;

	// replica table
	logic                pres_q  [TBL];
	logic                drain_q [TBL];
	logic                dead_q  [TBL];
	logic [CNT_W-1:0]    act_q   [TBL];
	logic [CNT_W-1:0]    cap_q   [TBL];
	logic [WEIGHT_W-1:0] wgt_q   [TBL];

	// select working registers
	logic [POS_W-1:0]    key_q;
	logic [MASK_W-1:0]   mask_q;
	logic [CW-1:0]       lo_q, hi_q, i_q;
	logic [AW-1:0]       p_q;
	logic [FW-1:0]       r_q;
	logic                have_q;
	logic [IDX_W-1:0]    best_q;
	logic [CNT_W-1:0]    best_a_q;
	logic [WEIGHT_W-1:0] best_w_q;
	logic [TIE_W-1:0]    ties_q;
	logic [PROD_W-1:0]   prod_q;
	logic [LFSR_W-1:0]   lfsr_q;
	logic                res_found_q;
	logic [IDX_W-1:0]    res_idx_q;
	logic                res_tier_q;
	logic                out_valid_q;

	logic                accept;
	logic [POS_W-1:0]    key_in;
	logic [CW-1:0]       mid;
	logic [IDX_W-1:0]    sel_num;
	logic                sel_in_range;
	logic [RW-1:0]       sidx;
	logic                sel_below_cap;
	logic                sel_excl;
	logic                wk_elig;
	logic                fb_elig;
	logic [WEIGHT_W-1:0] sel_w;
	logic [CNT_W-1:0]    mul_x;
	logic [WEIGHT_W-1:0] mul_y;
	logic [PROD_W-1:0]   prod;
	logic                score_lt;
	logic                score_eq;
	logic [LFSR_W-1:0]   lfsr_nx;
	logic                wk_last;
	logic                fb_end;
	logic                done_go;
	mod_req_t            mreq;
	mod_rsp_t            mrsp;

	assign accept = in_valid && !in_stall;
	assign key_in = key_hash[POS_W-1:0];
	assign mid    = CW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	// one status read port, shared by ring walk (owner) and fallback scan
	assign sel_num       = (state_q == S_WK_CHK) ? own_rd_q : IDX_W'(r_q);
	assign sel_in_range  = ({1'b0, sel_num} < (IDX_W + 1)'(TBL));
	assign sidx          = sel_num[RW-1:0];
	assign sel_below_cap = (cap_q[sidx] == '0) || (act_q[sidx] < cap_q[sidx]);
	assign sel_excl      = mask_q[sel_num];
	assign sel_w         = (wgt_q[sidx] == '0) ? WEIGHT_W'(1) : wgt_q[sidx];
	assign wk_elig = sel_in_range && !sel_excl && pres_q[sidx] && !drain_q[sidx]
		&& !dead_q[sidx] && sel_below_cap;
	assign fb_elig = pres_q[sidx] && !dead_q[sidx] && !sel_excl && sel_below_cap;

	// shared multiplier: candidate*best_w first, then best_a*candidate_w
	assign mul_x    = (state_q == S_FB_CMP) ? best_a_q : act_q[sidx];
	assign mul_y    = (state_q == S_FB_CMP) ? sel_w : best_w_q;
	assign prod     = mul_x * mul_y;
	assign score_lt = prod_q < prod;
	assign score_eq = prod_q == prod;

	assign lfsr_nx = {lfsr_q[LFSR_W-2:0],
		lfsr_q[15] ^ lfsr_q[13] ^ lfsr_q[12] ^ lfsr_q[10]};

	assign wk_last = (i_q + 1'b1) == count_q;
	assign fb_end  = (r_q == FW'(TBL));
	assign done_go = !out_valid_q || !out_stall;

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && cmd_t'(command) == CMD_SELECT)
					state_nx = (count_q == '0) ? S_FB_CHK : S_BS_RD;
			end
			S_BS_RD:  state_nx = (lo_q < hi_q) ? S_BS_CMP : S_WK_RD;
			S_BS_CMP: state_nx = S_BS_RD;
			S_WK_RD:  state_nx = S_WK_CHK;
			S_WK_CHK: begin
				if (wk_elig)
					state_nx = S_DONE;
				else if (wk_last)
					state_nx = S_FB_CHK;
				else
					state_nx = S_WK_RD;
			end
			S_FB_CHK: begin
				if (fb_end)
					state_nx = S_DONE;
				else if (fb_elig && have_q)
					state_nx = S_FB_CMP;
			end
			S_FB_CMP: state_nx = (!score_lt && score_eq) ? S_FB_MOD : S_FB_CHK;
			S_FB_MOD: state_nx = mrsp.done ? S_FB_CHK : S_FB_MOD;
			S_DONE:   state_nx = done_go ? S_IDLE : S_DONE;
			default:  state_nx = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_stall      = (state_q != S_IDLE);
		rd_addr       = p_q;
		mreq.start    = 1'b0;
		mreq.dividend = lfsr_nx;
		mreq.divisor  = ties_q + 1'b1;
		unique case (state_q)
			S_BS_RD:  rd_addr = mid[AW-1:0];
			S_FB_CMP: mreq.start = !score_lt && score_eq;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_nx;
	end

	// ring memory, single read port with registered data
	always_ff @(posedge clk) begin
		pos_rd_q <= pos_mem[rd_addr];
		own_rd_q <= own_mem[rd_addr];
		if (accept && cmd_t'(command) == CMD_APPEND) begin
			if (count_q != '0 && key_in == last_pos_q)
				own_mem[AW'(count_q - 1'b1)] <= replica_index;
			else if (count_q < CW'(RING_POINTS) && (count_q == '0 || key_in > last_pos_q)) begin
				pos_mem[count_q[AW-1:0]] <= key_in;
				own_mem[count_q[AW-1:0]] <= replica_index;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && cmd_t'(command) == CMD_CLEAR) begin
			count_q <= '0;
		end else if (accept && cmd_t'(command) == CMD_APPEND) begin
			if (!(count_q != '0 && key_in == last_pos_q) && count_q < CW'(RING_POINTS)
				&& (count_q == '0 || key_in > last_pos_q))
				count_q <= count_q + 1'b1;
		end
	end

	// copy of the top ring point, so appends need no memory read
	always_ff @(posedge clk) begin
		if (accept && cmd_t'(command) == CMD_APPEND && count_q < CW'(RING_POINTS)
			&& (count_q == '0 || key_in > last_pos_q))
			last_pos_q <= key_in;
	end

	// replica status table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TBL; k++) begin
				pres_q[k]  <= 1'b0;
				drain_q[k] <= 1'b0;
				dead_q[k]  <= 1'b0;
				act_q[k]   <= '0;
				cap_q[k]   <= '0;
				wgt_q[k]   <= WEIGHT_W'(16);
			end
		end else if (accept && cmd_t'(command) == CMD_STATUS
			&& {1'b0, replica_index} < (IDX_W + 1)'(TBL)) begin
			pres_q[replica_index[RW-1:0]]  <= present;
			drain_q[replica_index[RW-1:0]] <= draining;
			dead_q[replica_index[RW-1:0]]  <= dead;
			act_q[replica_index[RW-1:0]]   <= active_count;
			cap_q[replica_index[RW-1:0]]   <= cap_limit;
			wgt_q[replica_index[RW-1:0]]   <= weight;
		end
	end

	// tiebreak LFSR; seed of zero loads as one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			lfsr_q <= LFSR_W'(1);
		else if (cfg_we)
			lfsr_q <= (cfg_wdata == '0) ? LFSR_W'(1) : cfg_wdata;
		else if (mreq.start)
			lfsr_q <= lfsr_nx;
	end

	// select datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			r_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					have_q <= 1'b0;
					r_q    <= '0;
				end
				S_FB_CHK: begin
					if (!fb_end) begin
						if (!fb_elig)
							r_q <= r_q + 1'b1;
						else if (!have_q) begin
							have_q <= 1'b1;
							r_q    <= r_q + 1'b1;
						end
					end
				end
				S_FB_CMP: begin
					if (!(score_eq && !score_lt))
						r_q <= r_q + 1'b1;
				end
				S_FB_MOD: begin
					if (mrsp.done)
						r_q <= r_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				key_q  <= key_in;
				mask_q <= excluded_mask;
				lo_q   <= '0;
				hi_q   <= count_q;
			end
			S_BS_CMP: begin
				if (pos_rd_q < key_q)
					lo_q <= mid + 1'b1;
				else
					hi_q <= mid;
			end
			S_BS_RD: begin
				p_q <= (lo_q >= count_q) ? '0 : lo_q[AW-1:0];
				i_q <= '0;
			end
			S_WK_CHK: begin
				res_found_q <= 1'b1;
				res_idx_q   <= own_rd_q;
				res_tier_q  <= 1'b0;
				i_q         <= i_q + 1'b1;
				p_q         <= ((p_q + 1'b1) == AW'(count_q - 1'b1) + 1'b1
					&& CW'(p_q) + 1'b1 == count_q) ? '0 : p_q + 1'b1;
			end
			S_FB_CHK: begin
				prod_q <= prod;
				if (fb_end) begin
					res_found_q <= have_q;
					res_idx_q   <= have_q ? best_q : '0;
					res_tier_q  <= have_q;
				end else if (fb_elig && !have_q) begin
					best_q   <= sel_num;
					best_a_q <= act_q[sidx];
					best_w_q <= sel_w;
					ties_q   <= TIE_W'(1);
				end
			end
			S_FB_CMP: begin
				if (score_lt) begin
					best_q   <= sel_num;
					best_a_q <= act_q[sidx];
					best_w_q <= sel_w;
					ties_q   <= TIE_W'(1);
				end else if (score_eq) begin
					ties_q <= ties_q + 1'b1;
				end
			end
			S_FB_MOD: begin
				if (mrsp.done && mrsp.rem_zero)
					best_q <= sel_num;
			end
			default: ;
		endcase
	end

	ttrs_mod_unit u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.rsp    (mrsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (state_q == S_DONE && done_go)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && done_go) begin
			found          <= res_found_q;
			chosen_replica <= res_idx_q;
			tier           <= res_tier_q;
		end
	end

	assign out_valid = out_valid_q;

	`TTRS_ASSERT(a_count_bound, count_q <= CW'(RING_POINTS))
	`TTRS_IMPLY(a_not_found_zero, out_valid_q && !found, chosen_replica == '0 && !tier)
	`TTRS_IMPLY(a_tie_count, state_q == S_FB_MOD, ties_q >= TIE_W'(2))
	`TTRS_IMPLY(a_walk_bound, state_q == S_WK_CHK, i_q < count_q)

endmodule
`default_nettype wire

// ===== rtl/ttrs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// ttrs_mod_unit
// Restoring bit-serial remainder of the LFSR value by the tie count.
// ----------------------------------------------------------------------------
`default_nettype none
module ttrs_mod_unit (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ttrs_pkg::mod_req_t  req,
	output ttrs_pkg::mod_rsp_t  rsp
);
	import ttrs_pkg::*;

	localparam int BIT_W = $clog2(LFSR_W);

	logic                 busy_q;
	logic                 done_q;
	logic [BIT_W-1:0]     bit_q;
	logic [LFSR_W-1:0]    dvd_q;
	logic [TIE_W-1:0]     dvs_q;
	logic [TIE_W-1:0]     rem_q;
	logic [TIE_W:0]       trial;
	logic [TIE_W:0]       trial_sub;

	always_comb begin
		trial     = {rem_q, dvd_q[LFSR_W-1]};
		trial_sub = (trial >= {1'b0, dvs_q}) ? (trial - {1'b0, dvs_q}) : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= '0;
			end else if (busy_q) begin
				bit_q <= bit_q + 1'b1;
				if (bit_q == BIT_W'(LFSR_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[LFSR_W-2:0], 1'b0};
			rem_q <= trial_sub[TIE_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.rem_zero = (rem_q == '0);

endmodule
`default_nettype wire

// ===== sim/ttrs_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ttrs_checker
// Watches both channels and the seed port of the replica selector, keeps its
// own copy of the ring and replica table, and checks every pick it returns.
// ----------------------------------------------------------------------------
module ttrs_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire [ttrs_pkg::LFSR_W-1:0]     cfg_wdata,
	input  wire                            in_valid,
	input  wire                            in_stall,
	input  wire [1:0]                      command,
	input  wire [ttrs_pkg::KEY_W-1:0]      key_hash,
	input  wire [ttrs_pkg::IDX_W-1:0]      replica_index,
	input  wire                            present,
	input  wire                            draining,
	input  wire                            dead,
	input  wire [ttrs_pkg::CNT_W-1:0]      active_count,
	input  wire [ttrs_pkg::CNT_W-1:0]      cap_limit,
	input  wire [ttrs_pkg::WEIGHT_W-1:0]   weight,
	input  wire [ttrs_pkg::MASK_W-1:0]     excluded_mask,
	input  wire                            out_valid,
	input  wire                            out_stall,
	input  wire                            found,
	input  wire [ttrs_pkg::IDX_W-1:0]      chosen_replica,
	input  wire                            tier,
	output int                             errors,
	output int                             pending
);
	import ttrs_pkg::*;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] rep;
		logic             tier;
	} pick_t;

	logic [KEY_W-1:0]    pos_q [RING_POINTS_DEF];
	logic [IDX_W-1:0]    own_q [RING_POINTS_DEF];
	int                  pts;
	logic                pres [REPLICAS_DEF];
	logic                drn [REPLICAS_DEF];
	logic                ded [REPLICAS_DEF];
	logic [CNT_W-1:0]    act [REPLICAS_DEF];
	logic [CNT_W-1:0]    cap [REPLICAS_DEF];
	logic [WEIGHT_W-1:0] wgt [REPLICAS_DEF];
	logic [LFSR_W-1:0]   lfsr;
	pick_t               picks_due [$];

	function automatic logic has_room(int r);
		return cap[r] == '0 || act[r] < cap[r];
	endfunction

	// taps 16,14,13,11, new bit in at the bottom
	function automatic logic [LFSR_W-1:0] lfsr_next(logic [LFSR_W-1:0] s);
		return {s[14:0], s[15] ^ s[13] ^ s[12] ^ s[10]};
	endfunction

	task automatic pick_replica(input logic [KEY_W-1:0] key, input logic [MASK_W-1:0] mask,
			output pick_t p);
		int st;
		int q;
		int o;
		int ties;
		int best;
		logic have;
		logic [31:0] ba, bw, a, w;
		p = '0;
		st = 0;
		have = 1'b0;
		best = 0;
		ties = 0;
		ba = '0;
		bw = 32'd1;
		if (pts > 0) begin
			while (st < pts && pos_q[st] < key)
				st++;
			if (st >= pts)
				st = 0;
			for (int i = 0; i < pts; i++) begin
				q = st + i;
				if (q >= pts)
					q -= pts;
				o = int'(own_q[q]);
				if (!mask[o] && pres[o] && !drn[o] && !ded[o] && has_room(o)) begin
					p.found = 1'b1;
					p.rep = IDX_W'(o);
					p.tier = 1'b0;
					return;
				end
			end
		end
		for (int r = 0; r < REPLICAS_DEF; r++) begin
			if (!pres[r] || ded[r] || mask[r] || !has_room(r))
				continue;
			a = 32'(act[r]);
			w = (wgt[r] == '0) ? 32'd1 : 32'(wgt[r]);
			if (!have || a * bw < ba * w) begin
				have = 1'b1;
				best = r;
				ba = a;
				bw = w;
				ties = 1;
			end else if (a * bw == ba * w) begin
				ties++;
				lfsr = lfsr_next(lfsr);
				if (int'(lfsr) % ties == 0)
					best = r;
			end
		end
		p.found = have;
		p.rep = have ? IDX_W'(best) : '0;
		p.tier = have;
	endtask

	always @(posedge clk or negedge arst_n) begin
		pick_t got;
		pick_t want;
		if (!arst_n) begin
			pts = 0;
			for (int r = 0; r < REPLICAS_DEF; r++) begin
				pres[r] = 1'b0;
				drn[r] = 1'b0;
				ded[r] = 1'b0;
				act[r] = '0;
				cap[r] = '0;
				wgt[r] = WEIGHT_W'(16);
			end
			lfsr = LFSR_W'(1);
			picks_due.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				lfsr = (cfg_wdata == '0) ? LFSR_W'(1) : cfg_wdata;
			if (out_valid && !out_stall) begin
				got = '{found, chosen_replica, tier};
				if (picks_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected pick: found=%0d replica=%0d tier=%0d",
							found, chosen_replica, tier);
				end else begin
					want = picks_due.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10)
							$display({"pick mismatch: exp found=%0d replica=%0d tier=%0d, ",
								"got found=%0d replica=%0d tier=%0d"},
								want.found, want.rep, want.tier, found, chosen_replica, tier);
					end
				end
			end
			if (in_valid && !in_stall) begin
				case (cmd_t'(command))
					CMD_CLEAR: pts = 0;
					CMD_APPEND: begin
						if (pts > 0 && key_hash == pos_q[pts-1]) begin
							own_q[pts-1] = replica_index;
						end else if (pts < RING_POINTS_DEF
							&& (pts == 0 || key_hash > pos_q[pts-1])) begin
							pos_q[pts] = key_hash;
							own_q[pts] = replica_index;
							pts++;
						end
					end
					CMD_STATUS: begin
						pres[replica_index] = present;
						drn[replica_index] = draining;
						ded[replica_index] = dead;
						act[replica_index] = active_count;
						cap[replica_index] = cap_limit;
						wgt[replica_index] = weight;
					end
					default: begin
						pick_replica(key_hash, excluded_mask, want);
						picks_due.push_back(want);
					end
				endcase
			end
			pending = picks_due.size();
		end
	end

endmodule

// ===== sim/tb_two_tier_replica_selector_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_tier_replica_selector_unit
// Directed and random ring/status/select traffic under varying back-pressure,
// with picks checked by a separate checker module.
// ----------------------------------------------------------------------------
module tb_two_tier_replica_selector_unit;
	import ttrs_pkg::*;

	localparam int QUIET_LIMIT = 20000;  // idle cycles before the watchdog trips
	localparam int HOLD_CYCLES = 600;    // long receiver hold-off

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [LFSR_W-1:0]   cfg_wdata = '0;
	logic                in_valid = 1'b0;
	wire                 in_stall;
	logic [1:0]          command = '0;
	logic [KEY_W-1:0]    key_hash = '0;
	logic [IDX_W-1:0]    replica_index = '0;
	logic                present = 1'b0;
	logic                draining = 1'b0;
	logic                dead = 1'b0;
	logic [CNT_W-1:0]    active_count = '0;
	logic [CNT_W-1:0]    cap_limit = '0;
	logic [WEIGHT_W-1:0] weight = '0;
	logic [MASK_W-1:0]   excluded_mask = '0;
	wire                 out_valid;
	logic                out_stall = 1'b0;
	wire                 found;
	wire [IDX_W-1:0]     chosen_replica;
	wire                 tier;

	int errors;
	int pending;
	int snd_idle = 0;        // percent of cycles the sender holds back
	int rcv_idle = 0;        // percent of cycles the receiver stalls
	int hold_req = 0;        // bumped to ask the receiver for a long hold-off
	int hold_seen = 0;
	int items_sent = 0;
	int quiet = 0;

	two_tier_replica_selector_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .key_hash(key_hash), .replica_index(replica_index),
		.present(present), .draining(draining), .dead(dead),
		.active_count(active_count), .cap_limit(cap_limit),
		.weight(weight), .excluded_mask(excluded_mask),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .chosen_replica(chosen_replica), .tier(tier)
	);

	ttrs_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .key_hash(key_hash), .replica_index(replica_index),
		.present(present), .draining(draining), .dead(dead),
		.active_count(active_count), .cap_limit(cap_limit),
		.weight(weight), .excluded_mask(excluded_mask),
		.out_valid(out_valid), .out_stall(out_stall),
		.found(found), .chosen_replica(chosen_replica), .tier(tier),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Receiver: random stalls, plus a long hold-off on request. The hold-off
	// is counted here so the sender keeps pushing selects into a full block.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			out_stall <= ($urandom_range(99) < rcv_idle);
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// One transaction on the input channel. Called just after a rising edge;
	// returns at the edge where it was taken, with valid still high so the
	// next one can follow back to back.
	task automatic offer(input cmd_t cmd, input logic [KEY_W-1:0] key,
			input logic [IDX_W-1:0] idx, input logic pr, input logic dr, input logic de,
			input logic [CNT_W-1:0] act, input logic [CNT_W-1:0] cap,
			input logic [WEIGHT_W-1:0] w, input logic [MASK_W-1:0] mask);
		while ($urandom_range(99) < snd_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		key_hash <= key;
		replica_index <= idx;
		present <= pr;
		draining <= dr;
		dead <= de;
		active_count <= act;
		cap_limit <= cap;
		weight <= w;
		excluded_mask <= mask;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		items_sent++;
	endtask

	// Unused fields carry random junk so every bit moves.
	task automatic wipe_ring();
		offer(CMD_CLEAR, $urandom, IDX_W'($urandom), 1'($urandom), 1'($urandom),
			1'($urandom), CNT_W'($urandom), CNT_W'($urandom), WEIGHT_W'($urandom),
			MASK_W'($urandom));
	endtask

	task automatic put_point(input logic [KEY_W-1:0] key, input logic [IDX_W-1:0] idx);
		offer(CMD_APPEND, key, idx, 1'($urandom), 1'($urandom), 1'($urandom),
			CNT_W'($urandom), CNT_W'($urandom), WEIGHT_W'($urandom), MASK_W'($urandom));
	endtask

	task automatic set_replica(input logic [IDX_W-1:0] idx, input logic pr, input logic dr,
			input logic de, input logic [CNT_W-1:0] act, input logic [CNT_W-1:0] cap,
			input logic [WEIGHT_W-1:0] w);
		offer(CMD_STATUS, $urandom, idx, pr, dr, de, act, cap, w, MASK_W'($urandom));
	endtask

	task automatic pick(input logic [KEY_W-1:0] key, input logic [MASK_W-1:0] mask);
		offer(CMD_SELECT, key, IDX_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
			CNT_W'($urandom), CNT_W'($urandom), WEIGHT_W'($urandom), mask);
	endtask

	// Drain everything, allow for a trailing clear, append or status command,
	// then write the seed while the block is idle.
	task automatic load_seed(input logic [LFSR_W-1:0] seed);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= seed;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One well-formed scenario: rebuild the ring, rewrite some replicas,
	// then fire a handful of selects. Now and then a broken append slips in.
	task automatic scenario();
		int n;
		int m;
		int s;
		logic [32:0] k;
		logic [CNT_W-1:0] act;
		logic [CNT_W-1:0] cap;
		logic [WEIGHT_W-1:0] w;
		logic [MASK_W-1:0] mask;
		logic [KEY_W-1:0] key;
		wipe_ring();
		n = ($urandom_range(11) == 0) ? $urandom_range(200, 270) : $urandom_range(0, 12);
		k = 33'($urandom_range(0, 1000));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0: ;                                          // same point: owner replaced
				1: k = (k > 5000) ? k - $urandom_range(1, 5000) : k; // out of order
				default: k = k + (n > 100 ? $urandom_range(1, 1 << 24)
				                          : $urandom_range(1, 1 << 29));
			endcase
			if (k[32])
				k = 33'hFFFFFFFF;
			put_point(k[31:0], IDX_W'($urandom));
		end
		m = $urandom_range(1, 10);
		for (int i = 0; i < m; i++) begin
			act = ($urandom_range(4) == 0) ? CNT_W'($urandom) : CNT_W'($urandom_range(0, 3));
			case ($urandom_range(4))
				0, 1: cap = '0;
				2: cap = CNT_W'($urandom_range(1, 4));
				3: cap = 16'hFFFF;
				default: cap = CNT_W'($urandom);
			endcase
			case ($urandom_range(5))
				0, 1: w = 8'd16;
				2: w = 8'd32;
				3: w = 8'd0;
				4: w = 8'hFF;
				default: w = WEIGHT_W'($urandom);
			endcase
			set_replica(IDX_W'($urandom), $urandom_range(9) < 8, $urandom_range(3) == 0,
				$urandom_range(4) == 0, act, cap, w);
		end
		s = $urandom_range(2, 8);
		for (int i = 0; i < s; i++) begin
			case ($urandom_range(4))
				0, 1: mask = '0;
				2: mask = 16'h1 << $urandom_range(15);
				3: mask = 16'hFFFF;
				default: mask = MASK_W'($urandom);
			endcase
			key = ($urandom_range(3) == 0) ? k[31:0] : $urandom;
			pick(key, mask);
		end
	endtask

	initial begin
		logic [LFSR_W-1:0] seeds [6];
		int goal;
		seeds = '{16'd1, 16'hFFFF, 16'd0, 16'h8000, LFSR_W'($urandom), LFSR_W'($urandom)};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, reset seed. Empty ring and empty table first.
		snd_idle <= 13;
		rcv_idle <= 55;
		pick(32'h0, 16'h0);
		set_replica(4'd0, 1'b1, 1'b0, 1'b0, 16'd5, 16'd0, 8'd16);
		set_replica(4'd1, 1'b1, 1'b0, 1'b0, 16'd10, 16'd0, 8'd32);      // ties with 0
		set_replica(4'd2, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0, 8'd16);       // dead
		set_replica(4'd3, 1'b1, 1'b1, 1'b0, 16'd0, 16'd1, 8'd0);        // draining, zero weight
		set_replica(4'd4, 1'b1, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 8'hFF); // at capacity
		set_replica(4'd15, 1'b0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 8'hFF);
		put_point(32'd100, 4'd2);
		put_point(32'd200, 4'd4);
		put_point(32'd200, 4'd0);          // equal position replaces the owner
		put_point(32'd50, 4'd1);           // below the last point, dropped
		put_point(32'hFFFFFFFF, 4'd15);
		pick(32'd150, 16'h0);
		pick(32'hFFFFFFFF, 16'h0);         // wraps round the ring
		pick(32'h0, 16'h0001);             // ring exhausted, least loaded wins
		pick(32'h0, 16'h0009);
		pick(32'h0, 16'hFFFF);             // nothing eligible
		set_replica(4'd3, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0, 8'd16);
		pick(32'd5, 16'hFFFE);
		pick(32'd5, 16'h0004);             // ring walk passes owner 2 and settles on 0
		wipe_ring();
		pick(32'd5, 16'h0);
		pick(32'hA5A5A5A5, 16'h5A5A);

		// Random part: three idling modes, two seeds each.
		goal = 0;
		for (int ph = 0; ph < 6; ph++) begin
			load_seed(seeds[ph]);
			case (ph / 2)
				0: begin snd_idle <= 13; rcv_idle <= 55; end
				1: begin snd_idle <= 55; rcv_idle <= 13; end
				default: begin snd_idle <= 0; rcv_idle <= 0; end
			endcase
			if (ph == 4)
				hold_req <= hold_req + 1;   // fill the block while output is held
			goal += 205;
			while (items_sent < goal + 25)
				scenario();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ttrs_pkg.sv
rtl/ttrs_mod_unit.sv
rtl/two_tier_replica_selector_unit.sv
sim/ttrs_checker.sv
sim/tb_two_tier_replica_selector_unit.sv
